/* hdl/tea_pkg.sv */
package tea_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned ROUND_W = 8;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [WORD_W-1:0]  TEA_DELTA     = 32'h9E37_79B9;
    localparam logic [ROUND_W-1:0] ROUNDS_RESET  = 8'd32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS = 3'd4;

    // operation codes
    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    typedef struct packed {
        logic              action;
        logic [WORD_W-1:0] first_half;
        logic [WORD_W-1:0] second_half;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] result_first;
        logic [WORD_W-1:0] result_second;
    } t_out_item;

    typedef struct packed {
        logic [WORD_W-1:0] k0;
        logic [WORD_W-1:0] k1;
        logic [WORD_W-1:0] k2;
        logic [WORD_W-1:0] k3;
    } t_key;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic round;
        logic store;
    } t_dp_cmd;

    // half-round mix: ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb)
    function automatic logic [WORD_W-1:0] tea_mix(
        input logic [WORD_W-1:0] x,
        input logic [WORD_W-1:0] sum,
        input logic [WORD_W-1:0] ka,
        input logic [WORD_W-1:0] kb
    );
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        a = (x << 4) + ka;
        b = x + sum;
        c = (x >> 5) + kb;
        return a ^ b ^ c;
    endfunction

endpackage

/* hdl/tea_ctrl.sv */
module tea_ctrl import tea_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_stall,
    input  logic [ROUND_W-1:0] i_round_count,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output logic               o_idle,
    output t_dp_cmd            o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic               r_state;
    logic               n_state;
    logic [ROUND_W-1:0] r_cnt;
    logic [ROUND_W-1:0] n_cnt;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               out_free;
    logic               accept;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // sequence rounds, then hand the block to the output register
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = i_round_count;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (r_cnt != '0) begin
                    o_cmd.round = 1'b1;
                    n_cnt       = r_cnt - 1'b1;
                end else if (out_free) begin
                    o_cmd.store = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_idle      = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* hdl/tea_dp.sv */
module tea_dp import tea_pkg::*; (
    input  logic               i_clk,
    input  t_dp_cmd            i_cmd,
    input  t_in_item           i_in_data,
    input  t_key               i_key,
    input  logic [ROUND_W-1:0] i_round_count,
    output t_out_item          o_out_data
);

    logic              r_action;
    logic [WORD_W-1:0] r_v0;
    logic [WORD_W-1:0] r_v1;
    logic [WORD_W-1:0] r_sum;
    t_out_item         r_out;

    logic [WORD_W+ROUND_W-1:0] dec_prod;
    logic [WORD_W-1:0]         enc_v0;
    logic [WORD_W-1:0]         enc_v1;
    logic [WORD_W-1:0]         dec_v0;
    logic [WORD_W-1:0]         dec_v1;

    // decryption starts at delta times the round count
    assign dec_prod = TEA_DELTA * i_round_count;

    // one encryption round, sum already advanced
    assign enc_v0 = r_v0 + tea_mix(r_v1, r_sum, i_key.k0, i_key.k1);
    assign enc_v1 = r_v1 + tea_mix(enc_v0, r_sum, i_key.k2, i_key.k3);

    // one decryption round, in reverse order
    assign dec_v1 = r_v1 - tea_mix(r_v0, r_sum, i_key.k2, i_key.k3);
    assign dec_v0 = r_v0 - tea_mix(dec_v1, r_sum, i_key.k0, i_key.k1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_in_data.action;
            r_v0     <= i_in_data.first_half;
            r_v1     <= i_in_data.second_half;
            r_sum    <= (i_in_data.action == ACT_DECRYPT) ? dec_prod[WORD_W-1:0] : TEA_DELTA;
        end else if (i_cmd.round) begin
            if (r_action == ACT_DECRYPT) begin
                r_v0  <= dec_v0;
                r_v1  <= dec_v1;
                r_sum <= r_sum - TEA_DELTA;
            end else begin
                r_v0  <= enc_v0;
                r_v1  <= enc_v1;
                r_sum <= r_sum + TEA_DELTA;
            end
        end
    end

    // hold the finished block until the beat is taken
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_out.result_first  <= r_v0;
            r_out.result_second <= r_v1;
        end
    end

    assign o_out_data = r_out;

endmodule

/* hdl/tea_block_cipher.sv */
// TEA block cipher, one 64-bit block at a time, one round per clock.
// An accepted block is loaded, runs through its rounds, then is stored to the output register.
// The shared round unit takes no new block until the previous one has gone to the output register.
// A finished block waits in the output register while the next one is taken in.
// Reset (synchronous, active low): key words cleared, round count 32, no block pending.
module tea_block_cipher import tea_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    t_key               r_key;
    logic [ROUND_W-1:0] r_rounds;
    t_dp_cmd            cmd;
    logic               idle;

    assign o_cfg_ready = idle;

    // configuration registers; writes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key    <= '0;
            r_rounds <= ROUNDS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_KEY0:   r_key.k0 <= i_cfg_data;
                CFG_KEY1:   r_key.k1 <= i_cfg_data;
                CFG_KEY2:   r_key.k2 <= i_cfg_data;
                CFG_KEY3:   r_key.k3 <= i_cfg_data;
                CFG_ROUNDS: r_rounds <= i_cfg_data[ROUND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tea_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_out_stall   (i_out_stall),
        .i_round_count (r_rounds),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .o_idle        (idle),
        .o_cmd         (cmd)
    );

    tea_dp u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_in_data     (i_in_data),
        .i_key         (r_key),
        .i_round_count (r_rounds),
        .o_out_data    (o_out_data)
    );

endmodule

/* verif/tb_tea_block_cipher.sv */
`timescale 1ns / 1ps

module tb_tea_block_cipher;
    import tea_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASES         = 12;

    // indexes past the register list; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE5 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE7 = 3'd7;

    localparam logic [WORD_W-1:0] ALL_ONES = '1;
    localparam logic [WORD_W-1:0] ALL_ZERO = '0;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WORD_W-1:0]    i_cfg_data  = '0;

    // blocks waiting to be sent, and cipher outputs waiting to come back
    t_in_item  block_pend[$];
    t_out_item cipher_exp[$];

    // shadow of the key and round count registers
    logic [WORD_W-1:0]  key_q [4] = '{default: '0};
    logic [ROUND_W-1:0] rounds_q  = ROUNDS_RESET;

    int n_pushed     = 0;
    int n_accepted   = 0;
    int n_results    = 0;
    int n_errors     = 0;
    int send_gap     = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    int hold_asks    = 0;
    int hold_done    = 0;
    int quiet_cycles = 0;
    bit gaps_on      = 1'b0;

    tea_block_cipher DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // one half round: shifted copies of x plus key words, mixed with x plus sum
    function automatic logic [WORD_W-1:0] half_mix(input logic [WORD_W-1:0] x,
                                                   input logic [WORD_W-1:0] s,
                                                   input logic [WORD_W-1:0] ka,
                                                   input logic [WORD_W-1:0] kb);
        logic [WORD_W-1:0] sh_left;
        logic [WORD_W-1:0] sh_right;
        sh_left  = x << 4;
        sh_right = x >> 5;
        return (sh_left + ka) ^ (x + s) ^ (sh_right + kb);
    endfunction

    // full cipher under the current key and round count
    function automatic t_out_item tea_cipher(input t_in_item blk);
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
        logic [WORD_W-1:0] sum;
        t_out_item         res;
        v0 = blk.first_half;
        v1 = blk.second_half;
        if (blk.action == ACT_ENCRYPT) begin
            sum = '0;
            for (int r = 0; r < rounds_q; r++) begin
                sum = sum + TEA_DELTA;
                v0  = v0 + half_mix(v1, sum, key_q[0], key_q[1]);
                v1  = v1 + half_mix(v0, sum, key_q[2], key_q[3]);
            end
        end else begin
            // start from delta times the round count so decrypt undoes encrypt
            sum = TEA_DELTA * {{(WORD_W-ROUND_W){1'b0}}, rounds_q};
            for (int r = 0; r < rounds_q; r++) begin
                v1  = v1 - half_mix(v0, sum, key_q[2], key_q[3]);
                v0  = v0 - half_mix(v1, sum, key_q[0], key_q[1]);
                sum = sum - TEA_DELTA;
            end
        end
        res.result_first  = v0;
        res.result_second = v1;
        return res;
    endfunction

    function automatic t_in_item make_block(input logic act,
                                            input logic [WORD_W-1:0] a,
                                            input logic [WORD_W-1:0] b);
        t_in_item blk;
        blk.action      = act;
        blk.first_half  = a;
        blk.second_half = b;
        return blk;
    endfunction

    // word biased toward the extremes
    function automatic logic [WORD_W-1:0] pick_word();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return ALL_ZERO;
        if (sel == 1) return ALL_ONES;
        return $urandom;
    endfunction

    function automatic int pick_gap();
        int sel;
        if (!gaps_on) return 0;
        sel = $urandom_range(0, 99);
        if (sel < 60) return 0;
        if (sel < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_block(input t_in_item blk);
        block_pend.push_back(blk);
        n_pushed++;
    endtask

    // encrypt a block, then decrypt the predicted ciphertext back
    task automatic queue_round_trip(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
        t_in_item  plain;
        t_out_item ct;
        plain = make_block(ACT_ENCRYPT, a, b);
        ct    = tea_cipher(plain);
        queue_block(plain);
        queue_block(make_block(ACT_DECRYPT, ct.result_first, ct.result_second));
    endtask

    // hold until every sent block has come back
    task automatic wait_drained();
        do @(posedge i_clk);
        while (!(n_accepted == n_pushed && n_results == n_accepted));
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_KEY0:   key_q[0] = data;
            CFG_KEY1:   key_q[1] = data;
            CFG_KEY2:   key_q[2] = data;
            CFG_KEY3:   key_q[3] = data;
            CFG_ROUNDS: rounds_q = data[ROUND_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_cipher(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                                  input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3,
                                  input logic [ROUND_W-1:0] rounds);
        cfg_write(CFG_KEY0, k0);
        cfg_write(CFG_KEY1, k1);
        cfg_write(CFG_KEY2, k2);
        cfg_write(CFG_KEY3, k3);
        // junk in the upper bits of the round count word must be dropped
        cfg_write(CFG_ROUNDS, {$urandom_range(0, 1) ? ALL_ONES[WORD_W-1:ROUND_W]
                                                    : ALL_ZERO[WORD_W-1:ROUND_W], rounds});
    endtask

    // send blocks from the pending queue, with random gaps between beats
    always @(posedge i_clk) begin
        bit busy;
        if (i_rst_n) begin
            busy = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                cipher_exp.push_back(tea_cipher(i_in_data));
                n_accepted++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (block_pend.size() > 0) begin
                    i_in_data <= block_pend.pop_front();
                    busy = 1'b1;
                    send_gap = pick_gap();
                end
            end
            i_in_valid <= busy;
        end
    end

    // check each result beat against the oldest expectation; drive output stall
    always @(posedge i_clk) begin
        t_out_item want;
        bit        stall;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (cipher_exp.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("unexpected result beat: first=%h second=%h",
                                 o_out_data.result_first, o_out_data.result_second);
                end else begin
                    want = cipher_exp.pop_front();
                    n_results++;
                    if (o_out_data.result_first !== want.result_first ||
                        o_out_data.result_second !== want.result_second) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("result mismatch: expected %h %h, got %h %h",
                                     want.result_first, want.result_second,
                                     o_out_data.result_first, o_out_data.result_second);
                    end
                end
            end

            // a long hold-off when asked, otherwise short random stalls
            if (hold_done != hold_asks) begin
                hold_left = LONG_HOLD;
                hold_done = hold_asks;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                stall = 1'b1;
            end else if (gaps_on && $urandom_range(0, 99) < 25) begin
                stall = 1'b1;
                stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                          : $urandom_range(8, 40);
            end else begin
                stall = 1'b0;
            end
            i_out_stall <= stall;
        end
    end

    // end the run if nothing moves on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb_tea_block_cipher failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int n_items;
        int sel;
        int target;
        logic [ROUND_W-1:0] rounds;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero key, 32 rounds
        queue_block(make_block(ACT_ENCRYPT, ALL_ZERO, ALL_ZERO));
        queue_block(make_block(ACT_ENCRYPT, ALL_ONES, ALL_ONES));
        queue_block(make_block(ACT_DECRYPT, ALL_ZERO, ALL_ZERO));
        queue_block(make_block(ACT_DECRYPT, ALL_ONES, ALL_ONES));
        wait_drained();

        // all-ones key at the maximum round count
        program_cipher(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 8'd255);
        queue_block(make_block(ACT_ENCRYPT, ALL_ONES, ALL_ZERO));
        queue_block(make_block(ACT_DECRYPT, ALL_ZERO, ALL_ONES));
        queue_round_trip($urandom, $urandom);
        wait_drained();

        // zero rounds: blocks pass straight through
        program_cipher($urandom, $urandom, $urandom, $urandom, 8'd0);
        queue_block(make_block(ACT_ENCRYPT, $urandom, $urandom));
        queue_block(make_block(ACT_DECRYPT, $urandom, $urandom));
        wait_drained();

        // single round, alternating bit patterns
        program_cipher($urandom, $urandom, $urandom, $urandom, 8'd1);
        queue_block(make_block(ACT_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555));
        queue_block(make_block(ACT_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA));
        wait_drained();

        // standard round count, decrypt starts from the usual sum
        program_cipher($urandom, $urandom, $urandom, $urandom, 8'd32);
        queue_round_trip($urandom, $urandom);
        wait_drained();

        // odd round count, then writes to unused indexes that must change nothing
        program_cipher($urandom, $urandom, $urandom, $urandom, 8'd7);
        cfg_write(CFG_SPARE5, $urandom);
        cfg_write(CFG_SPARE6, $urandom);
        cfg_write(CFG_SPARE7, $urandom);
        queue_round_trip($urandom, $urandom);
        queue_block(make_block(ACT_DECRYPT, $urandom, $urandom));
        wait_drained();

        // random phases: fresh key and round count each, mostly short round counts
        for (int p = 0; p < PHASES; p++) begin
            if (p == 3)
                rounds = 8'd255;
            else if (p == 6)
                rounds = 8'd0;
            else if (p == 9)
                rounds = 8'd32;
            else
                rounds = ROUND_W'($urandom_range(1, 16));
            target = (p == 3) ? 8 : 50;
            program_cipher(pick_word(), pick_word(), pick_word(), pick_word(), rounds);
            gaps_on = (p % 3 != 0);

            // stall the output for a long stretch while blocks keep coming
            if (p == 1)
                hold_asks++;

            n_items = 0;
            while (n_items < target) begin
                // pause the sender, at most once, until everything is back
                if (p == 5 && n_items == target / 2)
                    wait_drained();
                sel = $urandom_range(0, 99);
                if (sel < 45) begin
                    queue_round_trip($urandom, $urandom);
                    n_items += 2;
                end else if (sel < 85) begin
                    queue_block(make_block(1'($urandom_range(0, 1)), $urandom, $urandom));
                    n_items++;
                end else begin
                    queue_block(make_block(1'($urandom_range(0, 1)), pick_word(), pick_word()));
                    n_items++;
                end
            end
            wait_drained();
        end

        // let any stray beat show up before judging
        wait_drained();
        repeat (int'(rounds_q) + 10) @(posedge i_clk);
        if (n_errors == 0 && cipher_exp.size() == 0)
            $display("tb_tea_block_cipher passed");
        else
            $display("tb_tea_block_cipher failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/tea_pkg.sv
hdl/tea_ctrl.sv
hdl/tea_dp.sv
hdl/tea_block_cipher.sv
verif/tb_tea_block_cipher.sv
